// File: rtl/bwt_pkg.sv
// Shared types, codes and the slot match function of the breakpoint/trace unit.
// No dependencies; compile first.
`default_nettype none

package bwt_pkg;

    localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF;

    // request codes
    localparam logic [2:0] REQ_EVENT       = 3'd0;
    localparam logic [2:0] REQ_ADD_SLOT    = 3'd1;
    localparam logic [2:0] REQ_CLEAR_SLOT  = 3'd2;
    localparam logic [2:0] REQ_CLEAR_TRACE = 3'd3;
    localparam logic [2:0] REQ_READ_FRAME  = 3'd4;

    // event kinds
    localparam logic [2:0] EV_EXEC     = 3'd0;
    localparam logic [2:0] EV_RD_BYTE  = 3'd1;
    localparam logic [2:0] EV_WR_BYTE  = 3'd2;
    localparam logic [2:0] EV_RD_WORD  = 3'd3;
    localparam logic [2:0] EV_WR_WORD  = 3'd4;

    // trigger kinds
    localparam logic [2:0] TRIG_PC     = 3'd1;
    localparam logic [2:0] TRIG_ACCESS = 3'd2;
    localparam logic [2:0] TRIG_VALUE  = 3'd3;
    localparam logic [2:0] TRIG_FULL   = 3'd4;

    // access modes
    localparam logic [1:0] MODE_READ  = 2'd0;
    localparam logic [1:0] MODE_WRITE = 2'd1;

    // slot actions
    localparam logic [1:0] ACT_BREAK    = 2'd1;
    localparam logic [1:0] ACT_ANNOTATE = 2'd2;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [2:0]  event_kind;
        logic [15:0] addr;
        logic [15:0] data;
        logic [2:0]  trig_kind;
        logic [1:0]  access_mode;
        logic [15:0] occur_count;
        logic [1:0]  action_kind;
        logic [31:0] index;
    } t_req;

    typedef struct packed {
        logic        break_hit;
        logic [7:0]  fired_mask;
        logic [7:0]  annotate_mask;
        logic [2:0]  slot_number;
        logic        add_failed;
        logic        frame_valid;
        logic [2:0]  frame_kind;
        logic [15:0] frame_addr;
        logic [15:0] frame_data;
        logic        buffer_full;
        logic [31:0] recorded_count;
    } t_rsp;

    typedef struct packed {
        logic [2:0]  trig;
        logic [1:0]  mode;
        logic [1:0]  act;
        logic [15:0] addr;
        logic [15:0] value;
        logic [15:0] count;
    } t_slot;

    // controller -> datapath
    typedef struct packed {
        logic capture;
        logic exec;
        logic rd_addr;
        logic rd_capture;
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic is_read;
        logic frame_ok;
    } t_dp_stat;

    function automatic logic slot_hit(t_slot s, logic [2:0] kind, logic [15:0] a,
                                      logic [15:0] d, logic full);
        logic rd;
        logic wr;
        logic dir;
        logic hit;
        rd = (kind == EV_RD_BYTE) || (kind == EV_RD_WORD);
        wr = (kind == EV_WR_BYTE) || (kind == EV_WR_WORD);
        case (s.mode)
            MODE_READ:  dir = rd;
            MODE_WRITE: dir = wr;
            default:    dir = 1'b1;
        endcase
        case (s.trig)
            TRIG_PC:     hit = (kind == EV_EXEC) && (a == s.addr);
            TRIG_ACCESS: hit = dir && (a == s.addr);
            TRIG_VALUE:  hit = dir && (a == s.addr) && (d == s.value);
            TRIG_FULL:   hit = full;
            default:     hit = 1'b0;
        endcase
        return hit;
    endfunction

endpackage

`default_nettype wire

// File: rtl/bwt_if.sv
// Valid/ready channel interfaces for requests and results.
// No dependencies.
`default_nettype none

interface bwt_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  req_type;
    logic [2:0]  event_kind;
    logic [15:0] addr;
    logic [15:0] data;
    logic [2:0]  trig_kind;
    logic [1:0]  access_mode;
    logic [15:0] occur_count;
    logic [1:0]  action_kind;
    logic [31:0] index;

    modport source (output valid, req_type, event_kind, addr, data, trig_kind,
                    access_mode, occur_count, action_kind, index, input ready);
    modport sink   (input valid, req_type, event_kind, addr, data, trig_kind,
                    access_mode, occur_count, action_kind, index, output ready);
endinterface

interface bwt_rsp_if;
    logic        valid;
    logic        ready;
    logic        break_hit;
    logic [7:0]  fired_mask;
    logic [7:0]  annotate_mask;
    logic [2:0]  slot_number;
    logic        add_failed;
    logic        frame_valid;
    logic [2:0]  frame_kind;
    logic [15:0] frame_addr;
    logic [15:0] frame_data;
    logic        buffer_full;
    logic [31:0] recorded_count;

    modport source (output valid, break_hit, fired_mask, annotate_mask, slot_number,
                    add_failed, frame_valid, frame_kind, frame_addr, frame_data,
                    buffer_full, recorded_count, input ready);
    modport sink   (input valid, break_hit, fired_mask, annotate_mask, slot_number,
                    add_failed, frame_valid, frame_kind, frame_addr, frame_data,
                    buffer_full, recorded_count, output ready);
endinterface

`default_nettype wire

// File: rtl/bwt_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module bwt_ram #(
    parameter int WIDTH = 35,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: rtl/bwt_datapath.sv
// Datapath: request register, event counter, trace ring, slot table and result register.
// Depends on bwt_pkg and bwt_ram.
`default_nettype none

module bwt_datapath #(
    parameter int SLOT_COUNT  = 8,
    parameter int TRACE_DEPTH = 256
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire bwt_pkg::t_dp_cmd i_cmd,
    input  wire bwt_pkg::t_req    i_req,
    output bwt_pkg::t_dp_stat     o_stat,
    output bwt_pkg::t_rsp         o_res
);
    import bwt_pkg::*;

    localparam int AW = (TRACE_DEPTH > 1) ? $clog2(TRACE_DEPTH) : 1;
    localparam int DW = AW + 1;
    localparam int RW = 35;

    t_req            r_req;
    t_rsp            r_res, n_res;
    logic [31:0]     r_cnt, n_cnt;
    logic [AW-1:0]   r_wptr, n_wptr;
    logic            r_used [SLOT_COUNT];
    logic            n_used [SLOT_COUNT];
    t_slot           r_slot [SLOT_COUNT];
    t_slot           n_slot [SLOT_COUNT];
    logic            r_frame_ok, n_frame_ok;
    logic [DW-1:0]   r_diff, n_diff;

    logic [15:0]     rec_data;
    logic            full_after;
    logic            found;
    logic [31:0]     diff;
    logic [DW-1:0]   wext;
    logic [DW-1:0]   pos_full;
    logic            ram_we;
    logic            ram_re;
    logic [AW-1:0]   ram_raddr;
    logic [RW-1:0]   ram_rdata;
    t_slot           new_slot;

    // recorded data: exec keeps none, byte accesses keep the low byte
    always_comb begin
        if (r_req.event_kind == EV_EXEC) begin
            rec_data = '0;
        end else if ((r_req.event_kind == EV_RD_BYTE) || (r_req.event_kind == EV_WR_BYTE)) begin
            rec_data = {8'd0, r_req.data[7:0]};
        end else begin
            rec_data = r_req.data;
        end
    end

    always_comb begin
        new_slot.trig  = r_req.trig_kind;
        new_slot.mode  = r_req.access_mode;
        new_slot.act   = r_req.action_kind;
        new_slot.addr  = r_req.addr;
        new_slot.value = r_req.data;
        new_slot.count = r_req.occur_count;
    end

    // ring position of a frame that lies diff frames behind the write pointer
    always_comb begin
        wext = {1'b0, r_wptr};
        if (wext >= r_diff) begin
            pos_full = wext - r_diff;
        end else begin
            pos_full = wext + DW'(TRACE_DEPTH) - r_diff;
        end
        ram_raddr = pos_full[AW-1:0];
    end

    always_comb begin
        n_res      = r_res;
        n_cnt      = r_cnt;
        n_wptr     = r_wptr;
        n_used     = r_used;
        n_slot     = r_slot;
        n_frame_ok = r_frame_ok;
        n_diff     = r_diff;
        ram_we     = 1'b0;
        ram_re     = 1'b0;
        full_after = 1'b0;
        found      = 1'b0;
        diff       = r_cnt - r_req.index;

        if (i_cmd.exec) begin
            n_res      = '0;
            n_frame_ok = 1'b0;
            case (r_req.req_type)
                REQ_EVENT: begin
                    if (r_cnt != CNT_MAX) begin
                        ram_we = 1'b1;
                        n_cnt  = r_cnt + 32'd1;
                        n_wptr = (r_wptr == AW'(TRACE_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
                    end
                    full_after = (n_cnt >= 32'(TRACE_DEPTH));
                    for (int i = 0; i < SLOT_COUNT; i++) begin
                        if (r_used[i] && slot_hit(r_slot[i], r_req.event_kind, r_req.addr,
                                                  rec_data, full_after)) begin
                            if (r_slot[i].count != 16'd0) begin
                                n_slot[i].count = r_slot[i].count - 16'd1;
                            end
                            if ((r_slot[i].count == 16'd0) || (r_slot[i].count == 16'd1)) begin
                                n_res.fired_mask[i] = 1'b1;
                                if (r_slot[i].act == ACT_BREAK) begin
                                    n_res.break_hit = 1'b1;
                                end
                                if (r_slot[i].act == ACT_ANNOTATE) begin
                                    n_res.annotate_mask[i] = 1'b1;
                                end
                            end
                        end
                    end
                end
                REQ_ADD_SLOT: begin
                    for (int i = 0; i < SLOT_COUNT; i++) begin
                        if (!found && !r_used[i]) begin
                            found             = 1'b1;
                            n_used[i]         = 1'b1;
                            n_slot[i]         = new_slot;
                            n_res.slot_number = 3'(i);
                        end
                    end
                    n_res.add_failed = !found;
                end
                REQ_CLEAR_SLOT: begin
                    for (int i = 0; i < SLOT_COUNT; i++) begin
                        if (r_req.index == 32'(i)) begin
                            n_used[i] = 1'b0;
                        end
                    end
                end
                REQ_CLEAR_TRACE: begin
                    n_cnt  = '0;
                    n_wptr = '0;
                end
                REQ_READ_FRAME: begin
                    n_frame_ok = (r_req.index < r_cnt) && (diff <= 32'(TRACE_DEPTH));
                    n_diff     = diff[DW-1:0];
                end
                default: begin
                end
            endcase
            n_res.buffer_full    = (n_cnt >= 32'(TRACE_DEPTH));
            n_res.recorded_count = n_cnt;
        end

        if (i_cmd.rd_addr) begin
            ram_re = 1'b1;
        end

        if (i_cmd.rd_capture) begin
            n_res.frame_valid = 1'b1;
            n_res.frame_kind  = ram_rdata[34:32];
            n_res.frame_addr  = ram_rdata[31:16];
            n_res.frame_data  = ram_rdata[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_wptr <= '0;
            for (int i = 0; i < SLOT_COUNT; i++) begin
                r_used[i] <= 1'b0;
            end
        end else begin
            r_cnt  <= n_cnt;
            r_wptr <= n_wptr;
            r_used <= n_used;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req <= i_req;
        end
        r_slot     <= n_slot;
        r_res      <= n_res;
        r_frame_ok <= n_frame_ok;
        r_diff     <= n_diff;
    end

    bwt_ram #(
        .WIDTH (RW),
        .DEPTH (TRACE_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_wptr),
        .i_wdata ({r_req.event_kind, r_req.addr, rec_data}),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_stat.is_read  = (r_req.req_type == REQ_READ_FRAME);
    assign o_stat.frame_ok = r_frame_ok;
    assign o_res           = r_res;

endmodule

`default_nettype wire

// File: rtl/bwt_ctrl.sv
// Controller: sequences one request at a time through the datapath and holds
// the result handshake. Depends on bwt_pkg.
`default_nettype none

module bwt_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire logic              i_out_ready,
    input  wire bwt_pkg::t_dp_stat i_stat,
    output logic                   o_in_ready,
    output logic                   o_out_valid,
    output bwt_pkg::t_dp_cmd       o_cmd
);
    import bwt_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_ADDR,
        S_RDWAIT,
        S_DONE
    } t_state;

    t_state r_state;
    logic   r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (i_stat.is_read) begin
                        r_state <= S_ADDR;
                    end else begin
                        r_state     <= S_DONE;
                        r_out_valid <= 1'b1;
                    end
                end
                S_ADDR: begin
                    // skip the ring read for a frame that is not held (not yet written or overwritten)
                    if (i_stat.frame_ok) begin
                        r_state <= S_RDWAIT;
                    end else begin
                        r_state     <= S_DONE;
                        r_out_valid <= 1'b1;
                    end
                end
                S_RDWAIT: begin
                    r_state     <= S_DONE;
                    r_out_valid <= 1'b1;
                end
                S_DONE: begin
                    if (i_out_ready) begin
                        r_state     <= S_IDLE;
                        r_out_valid <= 1'b0;
                    end
                end
                default: begin
                    r_state     <= S_IDLE;
                    r_out_valid <= 1'b0;
                end
            endcase
        end
    end

    assign o_in_ready       = (r_state == S_IDLE);
    assign o_out_valid      = r_out_valid;
    assign o_cmd.capture    = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.exec       = (r_state == S_EXEC);
    assign o_cmd.rd_addr    = (r_state == S_ADDR) && i_stat.frame_ok;
    assign o_cmd.rd_capture = (r_state == S_RDWAIT);

endmodule

`default_nettype wire

// File: rtl/breakpoint_watchpoint_trace_unit_top.sv
// Top level of the breakpoint, watchpoint and trace unit.
// Depends on bwt_pkg, bwt_if, bwt_ram, bwt_datapath and bwt_ctrl.
`default_nettype none

// Debug unit that sits beside a 16-bit CPU. A trace event beat is stored in a
// ring of TRACE_DEPTH frames (kind, address, data), the saturating event
// counter advances, and the event is checked against up to SLOT_COUNT slots
// (PC match, filtered access match, access plus value, or buffer full), each
// with an occurrence count and a break or annotate action. Other request
// beats add a slot in the lowest free place, clear a slot, clear the trace,
// or read an absolute frame number back. Every request beat gives exactly one
// result beat, which also reports the counter and the buffer-full flag.
// One request is in flight at a time: the request is registered, processed
// in one controller step and the result is held in an output register until
// taken. A frame read that hits a held frame also goes through the ring's
// read port, in an address state and then a registered data state; a frame
// read that misses the ring skips the ring read. The ring has no reset; it
// is only ever read at frames written since the last trace clear, so no
// clearing pass runs.

module breakpoint_watchpoint_trace_unit_top #(
    parameter int SLOT_COUNT  = 8,
    parameter int TRACE_DEPTH = 256
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    bwt_req_if.sink    i_req,
    bwt_rsp_if.source  o_rsp
);
    import bwt_pkg::*;

    t_req     req;
    t_rsp     res;
    t_dp_cmd  cmd;
    t_dp_stat stat;

    // gather the request beat into one word for the datapath
    always_comb begin
        req.req_type    = i_req.req_type;
        req.event_kind  = i_req.event_kind;
        req.addr        = i_req.addr;
        req.data        = i_req.data;
        req.trig_kind   = i_req.trig_kind;
        req.access_mode = i_req.access_mode;
        req.occur_count = i_req.occur_count;
        req.action_kind = i_req.action_kind;
        req.index       = i_req.index;
    end

    bwt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .i_out_ready (o_rsp.ready),
        .i_stat      (stat),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .o_cmd       (cmd)
    );

    bwt_datapath #(
        .SLOT_COUNT  (SLOT_COUNT),
        .TRACE_DEPTH (TRACE_DEPTH)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_req   (req),
        .o_stat  (stat),
        .o_res   (res)
    );

    // drive the result beat from the held result register
    assign o_rsp.break_hit      = res.break_hit;
    assign o_rsp.fired_mask     = res.fired_mask;
    assign o_rsp.annotate_mask  = res.annotate_mask;
    assign o_rsp.slot_number    = res.slot_number;
    assign o_rsp.add_failed     = res.add_failed;
    assign o_rsp.frame_valid    = res.frame_valid;
    assign o_rsp.frame_kind     = res.frame_kind;
    assign o_rsp.frame_addr     = res.frame_addr;
    assign o_rsp.frame_data     = res.frame_data;
    assign o_rsp.buffer_full    = res.buffer_full;
    assign o_rsp.recorded_count = res.recorded_count;

endmodule

`default_nettype wire

// File: verif/bwt_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the breakpoint/watchpoint/trace unit: watches both channels,
// predicts each result beat and compares it field by field. Uses bwt_pkg, bwt_if.

module bwt_checker #(
    parameter int SLOT_COUNT  = 8,
    parameter int TRACE_DEPTH = 256
) (
    input  logic i_clk,
    input  logic i_rst_n,
    bwt_req_if   i_req,
    bwt_rsp_if   i_rsp,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_checked,
    output int   o_events,
    output int   o_fired_events,
    output int   o_break_events,
    output int   o_frames_read
);
    import bwt_pkg::*;

    localparam int MAX_REPORTS = 200;

    // shadow state of the unit
    logic [2:0]  ring_kind [TRACE_DEPTH];
    logic [15:0] ring_addr [TRACE_DEPTH];
    logic [15:0] ring_data [TRACE_DEPTH];
    logic [31:0] evt_count;
    logic [SLOT_COUNT-1:0] slot_used;
    t_slot       slot_cfg [SLOT_COUNT];

    t_rsp result_q [$];
    t_req beat;
    t_rsp want;
    t_rsp got;
    int   fail_cnt = 0;
    int   checked = 0;
    int   events = 0;
    int   fired_events = 0;
    int   break_events = 0;
    int   frames_read = 0;

    function automatic logic dir_ok(logic [1:0] mode, logic [2:0] kind);
        logic is_rd;
        logic is_wr;
        is_rd = (kind == EV_RD_BYTE) || (kind == EV_RD_WORD);
        is_wr = (kind == EV_WR_BYTE) || (kind == EV_WR_WORD);
        case (mode)
            MODE_READ:  return is_rd;
            MODE_WRITE: return is_wr;
            default:    return 1'b1;
        endcase
    endfunction

    // Work out the result beat of one request and advance the shadow state.
    task automatic trace_unit_step(input t_req r, output t_rsp p);
        logic [15:0] rec_data;
        logic        hit;
        logic        fire;
        logic        placed;
        int unsigned pos;
        t_slot       s;
        p = '0;
        case (r.req_type)
            REQ_EVENT: begin
                rec_data = r.data;
                if (r.event_kind == EV_EXEC)
                    rec_data = '0;
                else if (r.event_kind == EV_RD_BYTE || r.event_kind == EV_WR_BYTE)
                    rec_data = {8'h00, r.data[7:0]};
                if (evt_count != CNT_MAX) begin
                    pos = evt_count % TRACE_DEPTH;
                    ring_kind[pos] = r.event_kind;
                    ring_addr[pos] = r.addr;
                    ring_data[pos] = rec_data;
                    evt_count++;
                end
                for (int i = 0; i < SLOT_COUNT; i++) begin
                    if (!slot_used[i])
                        continue;
                    s = slot_cfg[i];
                    case (s.trig)
                        TRIG_PC:     hit = (r.event_kind == EV_EXEC) && (r.addr == s.addr);
                        TRIG_ACCESS: hit = dir_ok(s.mode, r.event_kind) && (r.addr == s.addr);
                        TRIG_VALUE:  hit = dir_ok(s.mode, r.event_kind) && (r.addr == s.addr)
                                           && (rec_data == s.value);
                        TRIG_FULL:   hit = (evt_count >= TRACE_DEPTH);
                        default:     hit = 1'b0;
                    endcase
                    if (!hit)
                        continue;
                    fire = 1'b1;
                    if (s.count != 0) begin
                        slot_cfg[i].count = s.count - 1'b1;
                        fire = (slot_cfg[i].count == 0);
                    end
                    if (!fire)
                        continue;
                    p.fired_mask[i] = 1'b1;
                    if (s.act == ACT_BREAK)
                        p.break_hit = 1'b1;
                    if (s.act == ACT_ANNOTATE)
                        p.annotate_mask[i] = 1'b1;
                end
            end
            REQ_ADD_SLOT: begin
                placed = 1'b0;
                for (int i = 0; i < SLOT_COUNT; i++) begin
                    if (placed || slot_used[i])
                        continue;
                    slot_used[i]       = 1'b1;
                    slot_cfg[i].trig   = r.trig_kind;
                    slot_cfg[i].mode   = r.access_mode;
                    slot_cfg[i].act    = r.action_kind;
                    slot_cfg[i].addr   = r.addr;
                    slot_cfg[i].value  = r.data;
                    slot_cfg[i].count  = r.occur_count;
                    p.slot_number      = 3'(i);
                    placed             = 1'b1;
                end
                p.add_failed = !placed;
            end
            REQ_CLEAR_SLOT: begin
                if (r.index < SLOT_COUNT) begin
                    slot_used[r.index] = 1'b0;
                    slot_cfg[r.index]  = '0;
                end
            end
            REQ_CLEAR_TRACE: evt_count = '0;
            REQ_READ_FRAME: begin
                if (r.index < evt_count && (evt_count - r.index) <= TRACE_DEPTH) begin
                    pos          = r.index % TRACE_DEPTH;
                    p.frame_valid = 1'b1;
                    p.frame_kind  = ring_kind[pos];
                    p.frame_addr  = ring_addr[pos];
                    p.frame_data  = ring_data[pos];
                end
            end
            default: ;
        endcase
        p.buffer_full    = (evt_count >= TRACE_DEPTH);
        p.recorded_count = evt_count;
    endtask

    task automatic check_field(input string name, input logic [31:0] want_v,
                               input logic [31:0] got_v);
        if (got_v !== want_v) begin
            fail_cnt++;
            if (fail_cnt <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want_v, got_v);
            else if (fail_cnt == MAX_REPORTS + 1)
                $display("%0t: further mismatches not shown", $time);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            evt_count = '0;
            slot_used = '0;
            result_q.delete();
        end else begin
            // retire first: a result beat never belongs to a request taken on the same edge
            if (i_rsp.valid && i_rsp.ready) begin
                got = {i_rsp.break_hit, i_rsp.fired_mask, i_rsp.annotate_mask,
                       i_rsp.slot_number, i_rsp.add_failed, i_rsp.frame_valid,
                       i_rsp.frame_kind, i_rsp.frame_addr, i_rsp.frame_data,
                       i_rsp.buffer_full, i_rsp.recorded_count};
                if (result_q.size() == 0) begin
                    fail_cnt++;
                    $display("%0t: result beat with nothing outstanding, expected none, got %h",
                             $time, got);
                end else begin
                    want = result_q.pop_front();
                    check_field("break_hit",      32'(want.break_hit),     32'(got.break_hit));
                    check_field("fired_mask",     32'(want.fired_mask),    32'(got.fired_mask));
                    check_field("annotate_mask",  32'(want.annotate_mask),
                                32'(got.annotate_mask));
                    check_field("slot_number",    32'(want.slot_number),   32'(got.slot_number));
                    check_field("add_failed",     32'(want.add_failed),    32'(got.add_failed));
                    check_field("frame_valid",    32'(want.frame_valid),   32'(got.frame_valid));
                    check_field("frame_kind",     32'(want.frame_kind),    32'(got.frame_kind));
                    check_field("frame_addr",     32'(want.frame_addr),    32'(got.frame_addr));
                    check_field("frame_data",     32'(want.frame_data),    32'(got.frame_data));
                    check_field("buffer_full",    32'(want.buffer_full),   32'(got.buffer_full));
                    check_field("recorded_count", want.recorded_count,     got.recorded_count);
                    checked++;
                end
            end
            if (i_req.valid && i_req.ready) begin
                beat = {i_req.req_type, i_req.event_kind, i_req.addr, i_req.data,
                        i_req.trig_kind, i_req.access_mode, i_req.occur_count,
                        i_req.action_kind, i_req.index};
                trace_unit_step(beat, want);
                result_q.push_back(want);
                if (beat.req_type == REQ_EVENT) begin
                    events++;
                    if (want.fired_mask != 0)
                        fired_events++;
                    if (want.break_hit)
                        break_events++;
                end
                if (want.frame_valid)
                    frames_read++;
            end
        end
        o_pending      <= result_q.size();
        o_fail_count   <= fail_cnt;
        o_checked      <= checked;
        o_events       <= events;
        o_fired_events <= fired_events;
        o_break_events <= break_events;
        o_frames_read  <= frames_read;
    end

endmodule

// File: verif/tb.sv
`timescale 1ns / 100ps
// Testbench top for breakpoint_watchpoint_trace_unit_top: clock, reset, request
// stimulus, result back-pressure and the verdict. Uses bwt_pkg, bwt_if, bwt_checker.

module tb;
    import bwt_pkg::*;

    localparam int SLOTS        = 8;
    localparam int RING_DEPTH   = 256;
    localparam int RANDOM_ITEMS = 700;
    localparam int HOLD_CYCLES  = 200;
    localparam int DRAIN_CYCLES = 8;

    // codes the package leaves unnamed, plus out-of-range values the unit must tolerate
    localparam logic [2:0] REQ_UNKNOWN   = 3'd7;
    localparam logic [2:0] EV_UNKNOWN    = 3'd7;
    localparam logic [2:0] TRIG_NEVER    = 3'd0;
    localparam logic [2:0] TRIG_UNUSED   = 3'd7;
    localparam logic [1:0] MODE_ANY      = 2'd2;
    localparam logic [1:0] MODE_RESERVED = 2'd3;
    localparam logic [1:0] ACT_NONE      = 2'd0;
    localparam logic [1:0] ACT_RESERVED  = 2'd3;

    logic clk = 1'b0;
    logic rst_n;
    logic random_phase;

    int fail_count;
    int pending;
    int checked;
    int events;
    int fired_events;
    int break_events;
    int frames_read;

    // stimulus bookkeeping: events sent since the last trace clear, burst length left
    int unsigned traced = 0;
    int unsigned burst_left = 0;
    logic [15:0] hot_addr [8];
    logic [15:0] hot_data [4];

    bwt_req_if req_ch ();
    bwt_rsp_if rsp_ch ();

    breakpoint_watchpoint_trace_unit_top #(
        .SLOT_COUNT (SLOTS),
        .TRACE_DEPTH(RING_DEPTH)
    ) u_top (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_req  (req_ch),
        .o_rsp  (rsp_ch)
    );

    bwt_checker #(
        .SLOT_COUNT (SLOTS),
        .TRACE_DEPTH(RING_DEPTH)
    ) u_chk (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_req         (req_ch),
        .i_rsp         (rsp_ch),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_checked     (checked),
        .o_events      (events),
        .o_fired_events(fired_events),
        .o_break_events(break_events),
        .o_frames_read (frames_read)
    );

    always #6 clk = ~clk;

    // Mostly back-to-back, some short gaps, now and then a long one.
    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic t_req req_of(logic [2:0] rt, logic [2:0] kind, logic [15:0] a,
                                    logic [15:0] d, logic [2:0] trig, logic [1:0] mode,
                                    logic [15:0] occ, logic [1:0] act, logic [31:0] idx);
        t_req r;
        r.req_type    = rt;
        r.event_kind  = kind;
        r.addr        = a;
        r.data        = d;
        r.trig_kind   = trig;
        r.access_mode = mode;
        r.occur_count = occ;
        r.action_kind = act;
        r.index       = idx;
        return r;
    endfunction

    function automatic t_req add_of(logic [2:0] trig, logic [1:0] mode, logic [15:0] a,
                                    logic [15:0] value, logic [15:0] occ, logic [1:0] act);
        return req_of(REQ_ADD_SLOT, EV_EXEC, a, value, trig, mode, occ, act, 32'd0);
    endfunction

    function automatic t_req event_of(logic [2:0] kind, logic [15:0] a, logic [15:0] d);
        return req_of(REQ_EVENT, kind, a, d, TRIG_NEVER, MODE_READ, 16'd0, ACT_NONE, 32'd0);
    endfunction

    // Offer one request beat, hold it until taken, then idle for a while or not at all.
    // Valid stays high across back-to-back beats so it is never dropped and raised in one step.
    task automatic issue(input t_req r);
        int unsigned gap;
        req_ch.valid       <= 1'b1;
        req_ch.req_type    <= r.req_type;
        req_ch.event_kind  <= r.event_kind;
        req_ch.addr        <= r.addr;
        req_ch.data        <= r.data;
        req_ch.trig_kind   <= r.trig_kind;
        req_ch.access_mode <= r.access_mode;
        req_ch.occur_count <= r.occur_count;
        req_ch.action_kind <= r.action_kind;
        req_ch.index       <= r.index;
        do @(posedge clk); while (!req_ch.ready);
        if (r.req_type == REQ_EVENT)
            traced++;
        else if (r.req_type == REQ_CLEAR_TRACE)
            traced = 0;
        if (burst_left != 0) begin
            burst_left--;
            gap = 0;
        end else begin
            gap = idle_len();
        end
        if (gap != 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Drive every input to a known value while reset is held, then release reset.
    initial begin
        rst_n              <= 1'b0;
        random_phase       <= 1'b0;
        req_ch.valid       <= 1'b0;
        req_ch.req_type    <= REQ_EVENT;
        req_ch.event_kind  <= EV_EXEC;
        req_ch.addr        <= '0;
        req_ch.data        <= '0;
        req_ch.trig_kind   <= TRIG_NEVER;
        req_ch.access_mode <= MODE_READ;
        req_ch.occur_count <= '0;
        req_ch.action_kind <= ACT_NONE;
        req_ch.index       <= '0;
        rsp_ch.ready       <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Result side: random ready with gaps, occasional long ready-high stretches, and
    // during the random part long hold-offs so the unit backs up and stalls its input.
    initial begin : rsp_ready_drive
        int unsigned run_len;
        int unsigned gap;
        bit          held_once;
        held_once = 1'b0;
        do @(posedge clk); while (!rst_n);
        forever begin
            if (random_phase && (!held_once || $urandom_range(0, 59) == 0)) begin
                held_once = 1'b1;
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            run_len = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 6);
            repeat (run_len) @(posedge clk);
            gap = idle_len();
            if (gap != 0) begin
                rsp_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    end

    initial begin : stimulus
        t_req        r;
        logic [95:0] noise;
        int unsigned pick;
        int unsigned useful;
        do @(posedge clk); while (!rst_n);

        // ---- directed part ----
        // read back from an empty trace: frame not held
        issue(req_of(REQ_READ_FRAME, EV_EXEC, '0, '0, TRIG_NEVER, MODE_READ, '0, ACT_NONE, 32'd0));
        // fill all eight slots, one of each flavor, then overflow the table
        issue(add_of(TRIG_PC, MODE_READ, 16'h0100, 16'h0000, 16'd0, ACT_BREAK));
        issue(add_of(TRIG_ACCESS, MODE_WRITE, 16'hFFFF, 16'h0000, 16'd2, ACT_ANNOTATE));
        issue(add_of(TRIG_VALUE, MODE_READ, 16'h8000, 16'h00AB, 16'd0, ACT_BREAK));
        issue(add_of(TRIG_FULL, MODE_ANY, 16'h0000, 16'h0000, 16'd0, ACT_ANNOTATE));
        issue(add_of(TRIG_UNUSED, MODE_ANY, 16'h0100, 16'h0000, 16'd0, ACT_BREAK));
        issue(add_of(TRIG_NEVER, MODE_RESERVED, 16'h0100, 16'h0000, 16'd0, ACT_BREAK));
        issue(add_of(TRIG_ACCESS, MODE_RESERVED, 16'h0000, 16'h0000, 16'd0, ACT_RESERVED));
        issue(add_of(TRIG_ACCESS, MODE_ANY, 16'h1234, 16'hFFFF, 16'hFFFF, ACT_ANNOTATE));
        issue(add_of(TRIG_PC, MODE_ANY, 16'hFFFF, 16'hFFFF, 16'hFFFF, ACT_RESERVED));
        // PC hit; exec data is recorded as zero
        issue(event_of(EV_EXEC, 16'h0100, 16'hFFFF));
        // write watch counts down on each of two writes and fires on the second; a read of the same address is filtered
        issue(event_of(EV_WR_BYTE, 16'hFFFF, 16'hFFFF));
        issue(event_of(EV_WR_WORD, 16'hFFFF, 16'hFFFF));
        issue(event_of(EV_RD_BYTE, 16'hFFFF, 16'hFFFF));
        // byte read keeps the low byte only, so the value match fires
        issue(event_of(EV_RD_BYTE, 16'h8000, 16'h12AB));
        issue(event_of(EV_RD_WORD, 16'h8000, 16'h00AB));
        // unknown kind: full data recorded, only the any-access slot sees it
        issue(event_of(EV_UNKNOWN, 16'h0000, 16'hFFFF));
        issue(event_of(EV_EXEC, 16'h1234, 16'h5555));
        // frame read back: first frame, last frame, far out of range
        issue(req_of(REQ_READ_FRAME, EV_EXEC, '0, '0, TRIG_NEVER, MODE_READ, '0, ACT_NONE, 32'd0));
        issue(req_of(REQ_READ_FRAME, EV_EXEC, '0, '0, TRIG_NEVER, MODE_READ, '0, ACT_NONE, 32'd7));
        issue(req_of(REQ_READ_FRAME, EV_EXEC, '0, '0, TRIG_NEVER, MODE_READ, '0, ACT_NONE,
                     32'hFFFF_FFFF));
        // slot clears, one out of range; unknown request with every bit set; trace clear
        issue(req_of(REQ_CLEAR_SLOT, EV_EXEC, '0, '0, TRIG_NEVER, MODE_READ, '0, ACT_NONE, 32'd0));
        issue(req_of(REQ_CLEAR_SLOT, EV_EXEC, '0, '0, TRIG_NEVER, MODE_READ, '0, ACT_NONE,
                     32'hFFFF_FFFF));
        issue(req_of(REQ_UNKNOWN, EV_UNKNOWN, 16'hFFFF, 16'hFFFF, TRIG_UNUSED, MODE_RESERVED,
                     16'hFFFF, ACT_RESERVED, 32'hFFFF_FFFF));
        issue(req_of(REQ_CLEAR_TRACE, EV_EXEC, '0, '0, TRIG_NEVER, MODE_READ, '0, ACT_NONE, 32'd0));

        // ---- random part ----
        // A few hot addresses and values make slot matches common; the edges of the
        // address space are always among them.
        hot_addr[0] = 16'h0000;
        hot_addr[1] = 16'hFFFF;
        for (int i = 2; i < 8; i++)
            hot_addr[i] = 16'($urandom);
        hot_data[0] = 16'($urandom_range(0, 255));
        hot_data[1] = 16'($urandom_range(0, 255));
        hot_data[2] = 16'($urandom);
        hot_data[3] = 16'($urandom);
        random_phase <= 1'b1;

        useful = 0;
        while (useful < RANDOM_ITEMS) begin
            // start from noise so unused fields toggle too, then shape the meaningful ones
            noise = {$urandom, $urandom, $urandom};
            r     = noise[92:0];
            pick  = $urandom_range(0, 999);
            if (burst_left == 0 && $urandom_range(0, 49) == 0)
                burst_left = $urandom_range(20, 60);
            if (pick < 4) begin
                r.req_type = REQ_CLEAR_TRACE;
            end else if (pick < 24) begin
                r.req_type = 3'($urandom_range(REQ_READ_FRAME + 1, REQ_UNKNOWN));
            end else if (pick < 94) begin
                r.req_type = REQ_ADD_SLOT;
                if ($urandom_range(0, 9) < 8)
                    r.trig_kind = 3'($urandom_range(TRIG_PC, TRIG_FULL));
                if ($urandom_range(0, 19) != 0)
                    r.addr = hot_addr[$urandom_range(0, 7)];
                if ($urandom_range(0, 3) != 0)
                    r.data = hot_data[$urandom_range(0, 3)];
                pick = $urandom_range(0, 19);
                if (pick < 14)
                    r.occur_count = 16'($urandom_range(0, 3));
                else if (pick < 19)
                    r.occur_count = 16'($urandom_range(4, 20));
            end else if (pick < 154) begin
                r.req_type = REQ_CLEAR_SLOT;
                if ($urandom_range(0, 19) < 17)
                    r.index = 32'($urandom_range(0, SLOTS - 1));
            end else if (pick < 244) begin
                r.req_type = REQ_READ_FRAME;
                if (traced != 0 && $urandom_range(0, 9) != 0)
                    r.index = traced - $urandom_range(0, RING_DEPTH + 14);
            end else begin
                r.req_type = REQ_EVENT;
                if ($urandom_range(0, 19) < 17)
                    r.event_kind = 3'($urandom_range(EV_EXEC, EV_WR_WORD));
                if ($urandom_range(0, 9) < 7)
                    r.addr = hot_addr[$urandom_range(0, 7)];
                if ($urandom_range(0, 1) != 0)
                    r.data = hot_data[$urandom_range(0, 3)];
            end
            // unknown requests and out-of-range clears change nothing; do not count them
            if (r.req_type <= REQ_READ_FRAME &&
                !(r.req_type == REQ_CLEAR_SLOT && r.index >= SLOTS))
                useful++;
            issue(r);
        end
        req_ch.valid <= 1'b0;

        // ---- drain and verdict ----
        do @(posedge clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Run covered %0d result beats, %0d of them trace events (%0d fired a slot,",
                 checked, events, fired_events);
        $display("%0d requested a break) and %0d frames read back from the ring.",
                 break_events, frames_read);
        if (fail_count == 0)
            $display("breakpoint_watchpoint_trace_unit_top verification clean");
        else
            $display("breakpoint_watchpoint_trace_unit_top verification failed");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #10_000_000;
        $display("breakpoint_watchpoint_trace_unit_top verification failed");
        $finish;
    end

endmodule
